>>> hw/rtl/qse_pkg.sv
package qse_pkg;

  localparam int ValueWidth = 32;

  typedef struct packed {
    logic signed [ValueWidth-1:0] sample_value;
    logic                         is_last;
  } sample_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] sorted_value;
    logic                         end_of_run;
  } result_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic                         valid;
    logic                         take;
    logic signed [ValueWidth-1:0] value;
  } cell_link_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/quicksort_engine.sv
// Sorting engine for sets of signed 32-bit values.
// Sample channel: one value per beat; a beat with is_last set closes the set.
// Each accepted beat is inserted into a row of DEPTH compare
// cells that keeps the set in ascending order at all times, so no separate
// sort phase follows the load. Beats beyond DEPTH elements are dropped, but
// a dropped beat marked last still closes the set.
// Result channel: starting the cycle after the last sample beat, the sorted
// run leaves from cell zero at one beat per cycle while result_ready is high,
// smallest first, with end_of_run on the greatest element. Each sample beat
// that finds room inserts one element, and each delivered result beat shifts
// the cell row one step toward cell zero.
// sample_ready is low while a run drains. A stalled result beat holds the
// whole row, so the receiver may stall for any time without loss.
// Reset empties every cell and returns the engine to loading; no clearing
// pass is needed.
module quicksort_engine #(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  qse_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output qse_pkg::result_t result
);

  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic                 state;
  logic                 state_next;
  logic                 sample_beat;
  logic                 result_beat;
  logic                 full;
  qse_pkg::cell_ctrl_t  ctrl;
  qse_pkg::cell_link_t  link [DEPTH];
  qse_pkg::cell_link_t  up   [DEPTH];
  qse_pkg::cell_link_t  down [DEPTH];

  assign sample_ready = (state == StLoad);
  assign result_valid = (state == StDrain);
  assign sample_beat  = sample_valid && sample_ready;
  assign result_beat  = result_valid && result_ready;
  assign full         = link[DEPTH-1].valid;

  // Insert only while room remains; shift on each delivered beat
  assign ctrl.ins   = sample_beat && !full;
  assign ctrl.shift = result_beat;

  // Build the row of cells with fixed ends
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign up[i] = '{valid: 1'b0, take: 1'b0, value: '0};
    end else begin : g_mid_up
      assign up[i] = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign down[i] = '{valid: 1'b0, take: 1'b0, value: '0};
    end else begin : g_mid_down
      assign down[i] = link[i+1];
    end

    qse_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_value (sample.sample_value),
      .prev      (up[i]),
      .next      (down[i]),
      .link      (link[i])
    );
  end

  // Advance between loading and draining
  always_comb begin
    state_next = state;
    case (state)
      StLoad: begin
        if (sample_beat && sample.is_last) state_next = StDrain;
      end
      StDrain: begin
        if (result_beat && !link[1].valid) state_next = StLoad;
      end
      default: state_next = StLoad;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StLoad;
    end else begin
      state <= state_next;
    end
  end

  assign result.sorted_value = link[0].value;
  assign result.end_of_run   = !link[1].valid;

  // A draining run always has an element in cell zero
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> link[0].valid)
    else $error("result offered from an empty cell");

  // The row stays ordered at its head
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (link[0].valid && link[1].valid) |-> (link[0].value <= link[1].value))
    else $error("cell row out of order");

  // A beat that is not the end of the run is followed by another
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (result_beat && !result.end_of_run) |=> result_valid)
    else $error("run ended without end_of_run");

  // The end of the run leaves the row empty and returns to loading
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (result_beat && result.end_of_run) |=> (sample_ready && !link[0].valid))
    else $error("cells left after end_of_run");

endmodule

>>> hw/rtl/qse_cell.sv
module qse_cell (
  input  logic                                     clk,
  input  logic                                     rst,
  input  qse_pkg::cell_ctrl_t                      ctrl,
  input  logic signed [qse_pkg::ValueWidth-1:0]    new_value,
  input  qse_pkg::cell_link_t                      prev,
  input  qse_pkg::cell_link_t                      next,
  output qse_pkg::cell_link_t                      link
);

  logic                                  valid;
  logic signed [qse_pkg::ValueWidth-1:0] value;
  logic                                  take;

  // Claim the new value's slot when empty or holding something greater
  assign take = !valid || (new_value < value);

  assign link.valid = valid;
  assign link.take  = take;
  assign link.value = value;

  // Track occupancy: insert from the left, drain toward cell zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins && take) begin
      valid <= prev.take ? prev.valid : 1'b1;
    end else if (ctrl.shift) begin
      valid <= next.valid;
    end
  end

  // Move payload: take the left neighbor's value or the new one on insert
  always_ff @(posedge clk) begin
    if (ctrl.ins && take) begin
      value <= prev.take ? prev.value : new_value;
    end else if (ctrl.shift) begin
      value <= next.value;
    end
  end

endmodule
